[rtl/bsl_pkg.sv]
// bsl_pkg: shared constants, types and helpers for the bounded shift list
// depends on nothing; imported by bsl_cell and bounded_shift_list
`default_nettype none

package bsl_pkg;

  // list geometry
  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;

  // count runs from 0 to CAPACITY inclusive
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // width used to compare the read index against the count
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // port widths fixed by the interface
  localparam int PORT_WORD_W   = 32;
  localparam int PORT_COUNT_W  = 7;
  localparam int PORT_OP_W     = 3;
  localparam int PORT_INDEX_W  = 8;
  localparam int PORT_STATUS_W = 2;

  typedef logic [ELEM_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [PORT_OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef enum logic [PORT_STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controls broadcast to every cell
  typedef struct packed {
    logic shift_up;    // every entry moves one place toward the tail
    logic shift_down;  // every entry moves one place toward the head
    logic append;      // the cell at position count, one past the tail entry, loads the new word
  } ctl_t;

  // per-cell position matches
  typedef struct packed {
    logic wr_here;     // this cell sits at position count
    logic rd_here;     // this cell is the clamped read position
    logic last_here;   // this cell holds the tail entry
  } sel_t;

  // port word to stored word (masked or zero-extended)
  function automatic word_t to_word(input logic [PORT_WORD_W-1:0] w);
    logic [63:0] t;
    t = {32'b0, w};
    return t[ELEM_WIDTH-1:0];
  endfunction

  // stored word to port word (low bits shown)
  function automatic logic [PORT_WORD_W-1:0] to_port(input word_t w);
    logic [63:0] t;
    t = 64'(w);
    return t[PORT_WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/bsl_cell.sv]
// bsl_cell: one storage cell of the shift chain, holds one list entry
// depends on bsl_pkg for the word type and the control structs
`default_nettype none

module bsl_cell (
  input  wire logic          clk_i,
  input  wire bsl_pkg::ctl_t  ctl_i,
  input  wire bsl_pkg::sel_t  sel_i,
  input  wire bsl_pkg::word_t new_i,
  input  wire bsl_pkg::word_t prev_i,
  input  wire bsl_pkg::word_t next_i,
  output bsl_pkg::word_t     word_o,
  output bsl_pkg::word_t     rd_o,
  output bsl_pkg::word_t     last_o
);
  import bsl_pkg::*;

  word_t word_q;
  word_t word_d;

  // neighbour hand-over or local load
  always_comb begin
    word_d = word_q;
    if (ctl_i.shift_up) begin
      word_d = prev_i;
    end else if (ctl_i.shift_down) begin
      word_d = next_i;
    end else if (ctl_i.append && sel_i.wr_here) begin
      word_d = new_i;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // gated contributions to the read and tail buses
  assign word_o = word_q;
  assign rd_o   = sel_i.rd_here   ? word_q : '0;
  assign last_o = sel_i.last_here ? word_q : '0;

endmodule

`default_nettype wire

[rtl/bounded_shift_list.sv]
// bounded_shift_list: top level, chain of bsl_cell entries plus count and result stage
// depends on bsl_pkg and bsl_cell
//
// Usage: one input word carries an op (insert head, insert tail, remove head,
// remove tail, read), an element word and a signed read index. Each accepted
// word gives exactly one result word with the read word, head, tail, count and
// status. Both channels use valid/stall: a word moves when valid is high and
// stall is low.
// Path: the result passes through the pending-result register, then the output
// register. Acceptance updates the chain and picks the read word; head and tail
// are collected from the updated cells as the output register loads.
// Throughput: one word per cycle while the output is taken, set by the single
// pending-result register between the chain and the output register.
// Reset clears the count and all handshake state; the list starts empty and
// cell contents are not cleared. When the receiver stalls, the result is held
// and one more result waits in the pending register; then input stalls.
`default_nettype none

module bounded_shift_list (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [bsl_pkg::PORT_OP_W-1:0]       op_i,
  input  wire logic [bsl_pkg::PORT_WORD_W-1:0]     element_in_i,
  input  wire logic signed [bsl_pkg::PORT_INDEX_W-1:0] read_index_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [bsl_pkg::PORT_WORD_W-1:0]          read_word_o,
  output logic [bsl_pkg::PORT_WORD_W-1:0]          head_word_o,
  output logic [bsl_pkg::PORT_WORD_W-1:0]          tail_word_o,
  output logic [bsl_pkg::PORT_COUNT_W-1:0]         entry_count_o,
  output logic [bsl_pkg::PORT_STATUS_W-1:0]        status_o
);
  import bsl_pkg::*;

  localparam count_t CAP_CNT = CNT_W'(CAPACITY);

  // handshake and control state
  count_t  count_q, count_d;
  logic    pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  word_t   pend_rd_q, pend_rd_d;
  status_e pend_st_q, pend_st_d;

  // result register
  logic [PORT_WORD_W-1:0]   out_rd_q, out_head_q, out_tail_q;
  logic [PORT_COUNT_W-1:0]  out_cnt_q;
  status_e                  out_st_q;

  logic    accept, out_free, out_load;
  op_e     op;
  word_t   new_word;
  ctl_t    ctl;
  logic    is_full, is_empty, do_read;
  logic [CNT_W-1:0] pos;
  logic [CMP_W-1:0] idx_ext, cnt_ext;

  word_t cell_word [CAPACITY];
  word_t cell_rd   [CAPACITY];
  word_t cell_last [CAPACITY];
  sel_t  cell_sel  [CAPACITY];
  word_t rd_bus, last_bus;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = pend_q && out_free;

  assign op       = op_e'(op_i);
  assign new_word = to_word(element_in_i);
  assign is_full  = (count_q == CAP_CNT);
  assign is_empty = (count_q == '0);

  // clamp the read index into the occupied range
  assign idx_ext = CMP_W'({1'b0, read_index_i[PORT_INDEX_W-2:0]});
  assign cnt_ext = CMP_W'(count_q);
  always_comb begin
    if (read_index_i[PORT_INDEX_W-1]) begin
      pos = '0;
    end else if (idx_ext >= cnt_ext) begin
      pos = count_q - CNT_W'(1);
    end else begin
      pos = idx_ext[CNT_W-1:0];
    end
  end

  // op decode: chain controls, count update and status
  always_comb begin
    ctl       = '0;
    count_d   = count_q;
    pend_st_d = pend_st_q;
    do_read   = 1'b0;
    if (accept) begin
      pend_st_d = ST_DONE;
      unique case (op)
        OP_INS_HEAD: begin
          if (is_full) begin
            pend_st_d = ST_FULL;
          end else begin
            ctl.shift_up = 1'b1;
            count_d      = count_q + CNT_W'(1);
          end
        end
        OP_INS_TAIL: begin
          if (is_full) begin
            pend_st_d = ST_FULL;
          end else begin
            ctl.append = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
        end
        OP_REM_HEAD: begin
          if (is_empty) begin
            pend_st_d = ST_EMPTY;
          end else begin
            ctl.shift_down = 1'b1;
            count_d        = count_q - CNT_W'(1);
          end
        end
        OP_REM_TAIL: begin
          if (is_empty) begin
            pend_st_d = ST_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (is_empty) begin
            pend_st_d = ST_EMPTY;
          end else begin
            do_read = 1'b1;
          end
        end
        default: begin
          pend_st_d = ST_DONE;
        end
      endcase
    end
  end

  // chain of cells with per-position matches
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = new_word;
    end else begin : g_mid
      assign prev_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = new_word;
    end else begin : g_inner
      assign next_w = cell_word[i+1];
    end

    assign cell_sel[i].wr_here   = (count_q == CNT_W'(i));
    assign cell_sel[i].rd_here   = do_read && (pos == CNT_W'(i));
    assign cell_sel[i].last_here = (count_q == CNT_W'(i + 1));

    bsl_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .sel_i  (cell_sel[i]),
      .new_i  (new_word),
      .prev_i (prev_w),
      .next_i (next_w),
      .word_o (cell_word[i]),
      .rd_o   (cell_rd[i]),
      .last_o (cell_last[i])
    );
  end

  // one-hot buses: at most one cell drives each
  always_comb begin
    rd_bus   = '0;
    last_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus   = rd_bus | cell_rd[i];
      last_bus = last_bus | cell_last[i];
    end
  end

  // pending result and output valid
  always_comb begin
    pend_d      = pend_q;
    pend_rd_d   = pend_rd_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      pend_d    = 1'b1;
      pend_rd_d = rd_bus;
    end else if (out_load) begin
      pend_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_rd_q <= pend_rd_d;
    pend_st_q <= pend_st_d;
    if (out_load) begin
      out_rd_q   <= to_port(pend_rd_q);
      out_head_q <= is_empty ? '0 : to_port(cell_word[0]);
      out_tail_q <= to_port(last_bus);
      out_cnt_q  <= PORT_COUNT_W'(count_q);
      out_st_q   <= pend_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_word_o   = out_rd_q;
  assign head_word_o   = out_head_q;
  assign tail_word_o   = out_tail_q;
  assign entry_count_o = out_cnt_q;
  assign status_o      = out_st_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("count above capacity");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted word left no pending result");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && (op == OP_INS_HEAD || op == OP_INS_TAIL))
      |=> (count_q == $past(count_q)))
    else $error("insert into full list changed count");

  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_empty && (op == OP_REM_HEAD || op == OP_REM_TAIL))
      |=> (count_q == '0))
    else $error("removal from empty list changed count");

endmodule

`default_nettype wire
